// ===== hw/rtl/rtph_pkg.sv =====
// shared constants for the ray / triangle plane hit pipeline
package rtph_pkg;

    // pipeline depth beyond the coordinate width
    localparam int RTPH_LAT_BASE = 15;

endpackage

// ===== hw/rtl/ray_triangle_plane_hit_top.sv =====
// ray / triangle plane intersection with projected edge-sign inside test
//
// Fully pipelined: a new beat is taken on every cycle in which start is high,
// and busy never rises. Each beat comes out as a one-cycle done strobe with
// the hit point and flags; the receiver has to take it in that cycle. The depth is
// set by the restoring divider for the ray parameter, which resolves one
// quotient bit per stage (COORD_WIDTH + 4 stages), plus the stages for the
// plane normal, the dot products, the wide products and the edge tests.
module ray_triangle_plane_hit_top
    import rtph_pkg::*;
#(
    parameter int COORD_WIDTH = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [3*COORD_WIDTH-1:0]      ray_origin,
    input  logic [3*COORD_WIDTH-1:0]      ray_target,
    input  logic [3*COORD_WIDTH-1:0]      vertex_a,
    input  logic [3*COORD_WIDTH-1:0]      vertex_b,
    input  logic [3*COORD_WIDTH-1:0]      vertex_c,
    output logic                          done,
    output logic signed [COORD_WIDTH-1:0] hit_x,
    output logic signed [COORD_WIDTH-1:0] hit_y,
    output logic signed [COORD_WIDTH-1:0] hit_z,
    output logic                          inside_res,
    output logic                          parallel,
    output logic                          saturated
);

    localparam int CW   = COORD_WIDTH;
    localparam int DW   = CW + 1;          // coordinate differences
    localparam int PW   = 2 * DW;          // product of two differences
    localparam int NW   = PW + 1;          // normal component / edge value
    localparam int MW   = NW + DW;         // normal times difference
    localparam int SW   = MW + 2;          // numerator / denominator
    localparam int LO   = SW / 2;          // low split of the numerator
    localparam int HI   = SW - LO;
    localparam int PPW  = DW + SW;         // d times numerator
    localparam int NNW  = PPW + 2;         // dividend 2|p| + |den|
    localparam int QB   = CW + 3;          // quotient bits below the overflow bit
    localparam int RW   = NNW + QB;        // remainder width
    localparam int MAGW = CW + 2;
    localparam int SUMW = CW + 3;
    localparam int DIVB = 9;               // bank of the first divider stage
    localparam int HB   = DIVB + QB + 1;   // hit bank
    localparam int EB   = HB + 1;          // edge product bank
    localparam int LAT  = CW + RTPH_LAT_BASE;

    localparam logic [QB:0]       QBOUND = (QB+1)'(1) << (CW + 1);
    localparam logic signed [SUMW-1:0] CMAX = SUMW'((1 << (CW - 1)) - 1);
    localparam logic signed [SUMW-1:0] CMIN = -CMAX - SUMW'(1);

    typedef struct packed {
        logic [2:0][CW-1:0] o;
        logic [2:0][DW-1:0] d;
        logic [2:0][DW-1:0] w;
        logic [8:0][CW-1:0] v;
        logic               par;
        logic               dneg;
    } ctx_t;

    function automatic logic [DW-1:0] sdiff(input logic [CW-1:0] a, input logic [CW-1:0] b);
        return {a[CW-1], a} - {b[CW-1], b};
    endfunction

    // valid chain
    logic [LAT:1] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LAT-1:1], start};
        end
    end

    assign busy = 1'b0;
    assign done = vld_reg[LAT];

    // bank 1: unpack and differences
    ctx_t              ctx_reg [1:EB];
    logic [2:0][DW-1:0] e1_reg, e2_reg;
    ctx_t              ctx1_next;
    logic [2:0][DW-1:0] e1_next, e2_next;

    always_comb
    begin
        ctx1_next = '0;
        for (int k = 0; k < 3; k++)
        begin
            ctx1_next.o[k]   = ray_origin[k*CW +: CW];
            ctx1_next.d[k]   = sdiff(ray_target[k*CW +: CW], ray_origin[k*CW +: CW]);
            ctx1_next.w[k]   = sdiff(vertex_a[k*CW +: CW], ray_origin[k*CW +: CW]);
            ctx1_next.v[k]   = vertex_a[k*CW +: CW];
            ctx1_next.v[3+k] = vertex_b[k*CW +: CW];
            ctx1_next.v[6+k] = vertex_c[k*CW +: CW];
            e1_next[k] = sdiff(vertex_b[k*CW +: CW], vertex_a[k*CW +: CW]);
            e2_next[k] = sdiff(vertex_c[k*CW +: CW], vertex_a[k*CW +: CW]);
        end
    end

    // banks 2..8: normal, dot products, wide products, dividend
    logic signed [PW-1:0]     np_reg [6];
    logic signed [NW-1:0]     n_reg [3];
    logic signed [MW-1:0]     nw_reg [3];
    logic signed [MW-1:0]     nd_reg [3];
    logic signed [SW-1:0]     num_reg, den_reg;
    logic signed [DW+HI-1:0]  phi_reg [3];
    logic signed [DW+LO:0]    plo_reg [3];
    logic [SW-1:0]            md6_reg, md7_reg;
    logic signed [PPW-1:0]    p_reg [3];
    ctx_t                     ctx6_next;

    always_comb
    begin
        ctx6_next      = ctx_reg[5];
        ctx6_next.par  = (den_reg == '0);
        ctx6_next.dneg = den_reg[SW-1];
    end

    always_ff @(posedge clk)
    begin
        ctx_reg[1] <= ctx1_next;
        e1_reg     <= e1_next;
        e2_reg     <= e2_next;
        for (int i = 2; i <= EB; i++)
        begin
            ctx_reg[i] <= (i == 6) ? ctx6_next : ctx_reg[i-1];
        end
        // cross product terms
        np_reg[0] <= $signed(e1_reg[1]) * $signed(e2_reg[2]);
        np_reg[1] <= $signed(e2_reg[1]) * $signed(e1_reg[2]);
        np_reg[2] <= $signed(e1_reg[2]) * $signed(e2_reg[0]);
        np_reg[3] <= $signed(e2_reg[2]) * $signed(e1_reg[0]);
        np_reg[4] <= $signed(e1_reg[0]) * $signed(e2_reg[1]);
        np_reg[5] <= $signed(e2_reg[0]) * $signed(e1_reg[1]);
        for (int k = 0; k < 3; k++)
        begin
            n_reg[k]  <= NW'(np_reg[2*k]) - NW'(np_reg[2*k+1]);
            nw_reg[k] <= n_reg[k] * $signed(ctx_reg[3].w[k]);
            nd_reg[k] <= n_reg[k] * $signed(ctx_reg[3].d[k]);
        end
        num_reg <= SW'(nw_reg[0]) + SW'(nw_reg[1]) + SW'(nw_reg[2]);
        den_reg <= SW'(nd_reg[0]) + SW'(nd_reg[1]) + SW'(nd_reg[2]);
        // split product d * num
        for (int k = 0; k < 3; k++)
        begin
            phi_reg[k] <= $signed(ctx_reg[5].d[k]) * $signed(num_reg[SW-1:LO]);
            plo_reg[k] <= $signed(ctx_reg[5].d[k]) * $signed({1'b0, num_reg[LO-1:0]});
            p_reg[k]   <= (PPW'(phi_reg[k]) <<< LO) + PPW'(plo_reg[k]);
        end
        md6_reg <= den_reg[SW-1] ? SW'(-den_reg) : SW'(den_reg);
        md7_reg <= md6_reg;
    end

    // divider: one quotient bit per stage, top bit flags overflow
    logic [SW:0] d2_reg [0:QB+1];

    always_ff @(posedge clk)
    begin
        d2_reg[0] <= {md7_reg, 1'b0};
        for (int j = 1; j <= QB + 1; j++)
        begin
            d2_reg[j] <= d2_reg[j-1];
        end
    end

    logic [2:0][CW-1:0] hit_next;
    logic [2:0]         sat_lane;

    for (genvar k = 0; k < 3; k++) begin : g_lane
        logic [RW-1:0] rem_reg  [0:QB+1];
        logic [QB:0]   q_reg    [0:QB+1];
        logic          negq_reg [0:QB+1];
        logic [PPW-1:0] pabs;
        logic [MAGW-1:0] mag;
        logic signed [SUMW-1:0] sum;

        assign pabs = p_reg[k][PPW-1] ? PPW'(-p_reg[k]) : PPW'(p_reg[k]);

        always_ff @(posedge clk)
        begin
            rem_reg[0]  <= RW'(NNW'({pabs, 1'b0}) + NNW'(md7_reg));
            q_reg[0]    <= '0;
            negq_reg[0] <= p_reg[k][PPW-1] ^ ctx_reg[7].dneg;
            for (int j = 1; j <= QB + 1; j++)
            begin
                if (rem_reg[j-1] >= (RW'(d2_reg[j-1]) << (QB + 1 - j)))
                begin
                    rem_reg[j] <= rem_reg[j-1] - (RW'(d2_reg[j-1]) << (QB + 1 - j));
                    q_reg[j]   <= {q_reg[j-1][QB-1:0], 1'b1};
                end
                else
                begin
                    rem_reg[j] <= rem_reg[j-1];
                    q_reg[j]   <= {q_reg[j-1][QB-1:0], 1'b0};
                end
                negq_reg[j] <= negq_reg[j-1];
            end
        end

        // clamp quotient, add origin, saturate; a parallel ray passes the origin through
        always_comb
        begin
            mag = (q_reg[QB+1] > QBOUND) ? MAGW'(QBOUND) : MAGW'(q_reg[QB+1]);
            sum = SUMW'($signed(ctx_reg[HB-1].o[k]))
                + (negq_reg[QB+1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag}));
            if (ctx_reg[HB-1].par)
            begin
                hit_next[k] = ctx_reg[HB-1].o[k];
                sat_lane[k] = 1'b0;
            end
            else if (sum > CMAX)
            begin
                hit_next[k] = CMAX[CW-1:0];
                sat_lane[k] = 1'b1;
            end
            else if (sum < CMIN)
            begin
                hit_next[k] = CMIN[CW-1:0];
                sat_lane[k] = 1'b1;
            end
            else
            begin
                hit_next[k] = sum[CW-1:0];
                sat_lane[k] = 1'b0;
            end
        end
    end

    // hit bank
    logic [2:0][CW-1:0] hit_reg, hit2_reg;
    logic               sat_reg, sat2_reg;

    always_ff @(posedge clk)
    begin
        hit_reg  <= hit_next;
        sat_reg  <= |sat_lane;
        hit2_reg <= hit_reg;
        sat2_reg <= sat_reg;
    end

    // edge-sign tests in the xy, xz and zy projections
    logic [2:0] accept;

    for (genvar j = 0; j < 3; j++) begin : g_proj
        localparam int U = (j == 2) ? 2 : 0;
        localparam int V = (j == 1) ? 2 : 1;
        logic signed [PW-1:0] m1_reg [3];
        logic signed [PW-1:0] m2_reg [3];
        logic [2:0] neg, pos;

        for (genvar e = 0; e < 3; e++) begin : g_edge
            localparam int E2 = (e + 1) % 3;
            logic [CW-1:0] p2u, p2v, p3u, p3v;
            logic signed [NW-1:0] s;

            assign p2u = ctx_reg[HB].v[3*e + U];
            assign p2v = ctx_reg[HB].v[3*e + V];
            assign p3u = ctx_reg[HB].v[3*E2 + U];
            assign p3v = ctx_reg[HB].v[3*E2 + V];

            always_ff @(posedge clk)
            begin
                m1_reg[e] <= $signed(sdiff(hit_reg[U], p3u)) * $signed(sdiff(p2v, p3v));
                m2_reg[e] <= $signed(sdiff(p2u, p3u)) * $signed(sdiff(hit_reg[V], p3v));
            end

            assign s      = NW'(m1_reg[e]) - NW'(m2_reg[e]);
            assign neg[e] = s[NW-1];
            assign pos[e] = !s[NW-1] && (s != '0);
        end

        assign accept[j] = !((|neg) && (|pos));
    end

    // output bank
    logic signed [CW-1:0] hx_reg, hy_reg, hz_reg;
    logic                 ins_reg, par_reg, satq_reg;

    always_ff @(posedge clk)
    begin
        hx_reg   <= hit2_reg[0];
        hy_reg   <= hit2_reg[1];
        hz_reg   <= hit2_reg[2];
        ins_reg  <= (&accept) && !ctx_reg[EB].par;
        par_reg  <= ctx_reg[EB].par;
        satq_reg <= sat2_reg;
    end

    assign hit_x      = hx_reg;
    assign hit_y      = hy_reg;
    assign hit_z      = hz_reg;
    assign inside_res = ins_reg;
    assign parallel   = par_reg;
    assign saturated  = satq_reg;

endmodule

// ===== hw/rtl/rtph_chk.sv =====
// port-level checks for the ray / triangle plane hit pipeline
module rtph_chk
    import rtph_pkg::*;
#(
    parameter int COORD_WIDTH = 16
)
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          done,
    input logic signed [COORD_WIDTH-1:0] hit_x,
    input logic signed [COORD_WIDTH-1:0] hit_y,
    input logic signed [COORD_WIDTH-1:0] hit_z,
    input logic                          inside_res,
    input logic                          parallel,
    input logic                          saturated
);

    localparam int LAT = COORD_WIDTH + RTPH_LAT_BASE;
    localparam logic signed [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    // every beat leaves after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LAT done)
        else $error("result beat missing after fixed latency");

    // no beat out without a beat in
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result beat without matching start");

    // parallel case reports neither inside nor clamp
    a_parallel: assert property (@(posedge clk) disable iff (!rst_n)
        (done && parallel) |-> (!inside_res && !saturated))
        else $error("parallel beat carries inside or saturated");

    // a clamp shows a coordinate at a range limit
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && saturated) |-> (hit_x == CMAX || hit_x == CMIN || hit_y == CMAX
            || hit_y == CMIN || hit_z == CMAX || hit_z == CMIN))
        else $error("saturated without a clamped coordinate");

    // the pipeline never pushes back
    a_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

endmodule

bind ray_triangle_plane_hit_top rtph_chk #(.COORD_WIDTH(COORD_WIDTH)) u_rtph_chk (.*);
